// ----- rtl/cfws_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the circular FIFO with statistics.
// No dependencies; imported by the interfaces, the store, the top level and the checker.
package cfws_pkg;

   localparam int DEPTH_DEFAULT = 256;
   localparam int CMD_W         = 2;
   localparam int VAL_W         = 32;
   localparam int ENTRY_W       = 31;
   localparam int LVL_W         = 9;
   localparam int CNT_W         = 32;
   localparam int STAT_W        = 2;
   localparam int CAP_W         = 9;

   localparam logic [CAP_W-1:0]        CAP_RESET = 9'd256;
   localparam logic signed [VAL_W-1:0] MINUS_ONE = -32'sd1;
   localparam logic [CNT_W-1:0]        CNT_MAX   = '1;

   typedef enum logic [CMD_W-1:0] {
      CMD_QUERY = 2'd0,
      CMD_PUSH  = 2'd1,
      CMD_POP   = 2'd2
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_NEG   = 2'd3
   } status_type;

endpackage

// ----- rtl/cfws_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response words.
// Depends on cfws_pkg for field widths.
interface cfws_req_if import cfws_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          cmd;
   logic signed [VAL_W-1:0]   push_value;

   modport source (output valid, output cmd, output push_value, input ready);
   modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface cfws_rsp_if import cfws_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [STAT_W-1:0]         status;
   logic signed [VAL_W-1:0]   popped_value;
   logic signed [VAL_W-1:0]   head_value;
   logic [LVL_W-1:0]          fill_level;
   logic                      is_empty;
   logic [CNT_W-1:0]          push_count;
   logic [CNT_W-1:0]          pop_count;
   logic [LVL_W-1:0]          high_water;

   modport source (output valid, output status, output popped_value, output head_value,
                   output fill_level, output is_empty, output push_count, output pop_count,
                   output high_water, input ready);
   modport sink   (input valid, input status, input popped_value, input head_value,
                   input fill_level, input is_empty, input push_count, input pop_count,
                   input high_water, output ready);
endinterface

// ----- rtl/cfws_store.sv -----
`timescale 1ns / 1ps
// Entry store: one write port, two registered read ports with write-first bypass.
// Depends on cfws_pkg for the entry width.
module cfws_store import cfws_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [ENTRY_W-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr_b,
   output logic [ENTRY_W-1:0]         rd_data_a,
   output logic [ENTRY_W-1:0]         rd_data_b
);

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] q_a_ff;
   logic [ENTRY_W-1:0] q_b_ff;
   logic [ENTRY_W-1:0] wdata_ff;
   logic               byp_a_ff;
   logic               byp_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      q_a_ff   <= mem[rd_addr_a];
      q_b_ff   <= mem[rd_addr_b];
      wdata_ff <= wr_data;
      // a word written in the read cycle wins over the old array content
      byp_a_ff <= wr_en && (wr_addr == rd_addr_a);
      byp_b_ff <= wr_en && (wr_addr == rd_addr_b);
   end

   assign rd_data_a = byp_a_ff ? wdata_ff : q_a_ff;
   assign rd_data_b = byp_b_ff ? wdata_ff : q_b_ff;

endmodule

// ----- rtl/circular_fifo_with_stats.sv -----
`timescale 1ns / 1ps
// Circular FIFO of non-negative 31-bit values with push/pop count and high-water statistics.
// Each request word (query, push or pop) yields one response word, and one request is
// taken every cycle unless stalled: the pointer, count and counter updates are single-step
// logic, and the entry store keeps the current head and the entry behind it ready in two
// registered read ports, so a pop hands over the next head without a wait. The response
// is valid in the next cycle; the response register holds one word, and req_ch.ready
// drops only while that word sits untaken with rsp_ch.ready low. The capacity register
// may be written only while no request is in flight. The store is not cleared after reset;
// no clearing pass is needed since only written entries are ever read.
// Depends on cfws_pkg, cfws_if and cfws_store.
module circular_fifo_with_stats import cfws_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   cfws_req_if.sink           req_ch,
   cfws_rsp_if.source         rsp_ch,
   input  logic               csr_we,
   input  logic [CAP_W-1:0]   csr_wdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   function automatic logic [CW-1:0] eff_cap(input logic [CAP_W-1:0] raw);
      logic [CW-1:0] c;
      if (raw == '0) begin
         c = CW'(1);
      end else if (32'(raw) > 32'(DEPTH)) begin
         c = CW'(DEPTH);
      end else begin
         c = CW'(raw);
      end
      return c;
   endfunction

   function automatic logic [AW-1:0] step_pos(input logic [AW-1:0] pos,
                                              input logic [CW-1:0] cap);
      logic [CW-1:0] p1;
      p1 = CW'(pos) + CW'(1);
      return (p1 >= cap) ? '0 : AW'(p1);
   endfunction

   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic [CW-1:0]      cap_cur, cap_nxt;
   logic [AW-1:0]      rp_ff, rp_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]   pushes_ff, pushes_in;
   logic [CNT_W-1:0]   pops_ff, pops_in;
   logic [CW-1:0]      peak_ff, peak_in;
   logic               rsp_valid_ff;

   logic               accept;
   logic               wr_en;
   logic               pop_ok;
   logic [AW-1:0]      wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [AW-1:0]      rd_addr_b;
   logic [ENTRY_W-1:0] head_cur;
   logic [ENTRY_W-1:0] next_cur;
   logic [SW-1:0]      pos_sum, pos_once, pos_twice;
   status_type         status;
   logic signed [VAL_W-1:0] popped;
   logic signed [VAL_W-1:0] head_after;

   logic [STAT_W-1:0]       status_ff;
   logic signed [VAL_W-1:0] popped_ff;
   logic signed [VAL_W-1:0] head_ff;
   logic [LVL_W-1:0]        fill_ff;
   logic                    empty_ff;
   logic [LVL_W-1:0]        hwm_ff;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign cap_in  = csr_we ? csr_wdata : cap_ff;
   assign cap_cur = eff_cap(cap_ff);
   assign cap_nxt = eff_cap(cap_in);

   // tail slot: head plus count, folded back by capacity then by storage depth
   assign pos_sum   = SW'(rp_ff) + SW'(count_ff);
   assign pos_once  = (pos_sum >= SW'(cap_cur)) ? pos_sum - SW'(cap_cur) : pos_sum;
   assign pos_twice = (pos_once >= SW'(DEPTH)) ? pos_once - SW'(DEPTH) : pos_once;
   assign wr_addr   = AW'(pos_twice);
   assign wr_data   = req_ch.push_value[ENTRY_W-1:0];

   always_comb begin
      rp_in     = rp_ff;
      count_in  = count_ff;
      pushes_in = pushes_ff;
      pops_in   = pops_ff;
      status    = ST_OK;
      popped    = MINUS_ONE;
      wr_en     = 1'b0;
      pop_ok    = 1'b0;
      if (accept) begin
         case (cmd_type'(req_ch.cmd))
            CMD_PUSH: begin
               if (req_ch.push_value[VAL_W-1]) begin
                  status = ST_NEG;
               end else if (count_ff >= cap_cur) begin
                  status = ST_FULL;
               end else begin
                  wr_en     = 1'b1;
                  count_in  = count_ff + CW'(1);
                  pushes_in = (pushes_ff == CNT_MAX) ? pushes_ff : pushes_ff + CNT_W'(1);
               end
            end
            CMD_POP: begin
               if (count_ff == '0) begin
                  status = ST_EMPTY;
               end else begin
                  pop_ok   = 1'b1;
                  popped   = {1'b0, head_cur};
                  rp_in    = step_pos(rp_ff, cap_cur);
                  count_in = count_ff - CW'(1);
                  pops_in  = (pops_ff == CNT_MAX) ? pops_ff : pops_ff + CNT_W'(1);
               end
            end
            CMD_QUERY: begin
            end
            default: begin
            end
         endcase
      end
      peak_in = (count_in > peak_ff) ? count_in : peak_ff;

      if (count_in == '0) begin
         head_after = MINUS_ONE;
      end else if (pop_ok) begin
         head_after = {1'b0, next_cur};
      end else if (wr_en && (wr_addr == rp_ff)) begin
         head_after = {1'b0, wr_data};
      end else begin
         head_after = {1'b0, head_cur};
      end
   end

   // keep the head and the slot behind it fetched for the coming cycle
   assign rd_addr_b = step_pos(rp_in, cap_nxt);

   cfws_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rp_in),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (head_cur),
      .rd_data_b (next_cur)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         rp_ff        <= '0;
         count_ff     <= '0;
         pushes_ff    <= '0;
         pops_ff      <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff    <= cap_in;
         rp_ff     <= rp_in;
         count_ff  <= count_in;
         pushes_ff <= pushes_in;
         pops_ff   <= pops_in;
         peak_ff   <= peak_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status;
         popped_ff <= popped;
         head_ff   <= head_after;
         fill_ff   <= LVL_W'(count_in);
         empty_ff  <= (count_in == '0);
         hwm_ff    <= LVL_W'(peak_in);
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.popped_value = popped_ff;
   assign rsp_ch.head_value   = head_ff;
   assign rsp_ch.fill_level   = fill_ff;
   assign rsp_ch.is_empty     = empty_ff;
   assign rsp_ch.push_count   = pushes_ff;
   assign rsp_ch.pop_count    = pops_ff;
   assign rsp_ch.high_water   = hwm_ff;

endmodule

// ----- rtl/cfws_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for circular_fifo_with_stats, attached by the bind below.
// Depends on cfws_pkg for status codes and field widths.
module cfws_checker import cfws_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [STAT_W-1:0]         rsp_status,
   input logic signed [VAL_W-1:0]   rsp_popped_value,
   input logic signed [VAL_W-1:0]   rsp_head_value,
   input logic [LVL_W-1:0]          rsp_fill_level,
   input logic                      rsp_is_empty,
   input logic [LVL_W-1:0]          rsp_high_water
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_head_value)
                                  && $stable(rsp_fill_level))
      else $error("response word changed while stalled");

   // a new response word only follows an accepted request word
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid && !rsp_ready) |-> $past(req_valid && req_ready))
      else $error("response word without a request word");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_fill_level == '0))
                    && (!rsp_is_empty || rsp_head_value == MINUS_ONE))
      else $error("empty flag, fill level and head disagree");

   a_high_water: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_high_water >= rsp_fill_level)
      else $error("high-water mark below fill level");

   a_refused_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_is_empty && rsp_popped_value == MINUS_ONE)
      else $error("refused pop with data or entries");

endmodule

bind circular_fifo_with_stats cfws_checker u_cfws_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_status       (rsp_ch.status),
   .rsp_popped_value (rsp_ch.popped_value),
   .rsp_head_value   (rsp_ch.head_value),
   .rsp_fill_level   (rsp_ch.fill_level),
   .rsp_is_empty     (rsp_ch.is_empty),
   .rsp_high_water   (rsp_ch.high_water)
);
